[rtl/core/tick_to_time_scaler_macros.svh]
// tick_to_time_scaler_macros.svh: assertion macros for the tick to time scaler
// expects signals named clk and rst (synchronous, active high) in the using scope
`ifndef TICK_TO_TIME_SCALER_MACROS_SVH
`define TICK_TO_TIME_SCALER_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define TTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/tts_pkg.sv]
// tts_pkg.sv: shared constants and types of the tick to time scaler
// no dependencies
`timescale 1ns / 1ps

package tts_pkg;

  localparam int TIME_W   = 64;
  localparam int FREQ_W   = 32;
  localparam int MS_NUM_W = 10;
  localparam int NS_NUM_W = 30;
  localparam int CNT_W    = 7;

  localparam logic [FREQ_W-1:0] MS_PER_SEC = 32'd1000;
  localparam logic [FREQ_W-1:0] NS_PER_SEC = 32'd1000000000;
  localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd1000000;

  localparam logic [CNT_W-1:0] DIV_STEPS_LONG  = 7'd64;
  localparam logic [CNT_W-1:0] DIV_STEPS_SHORT = 7'd32;

  // requested unit codes
  localparam logic REQ_MS = 1'b0;
  localparam logic REQ_NS = 1'b1;

  // divider launch control
  typedef struct packed {
    logic start;
    logic len32;
  } div_ctl_t;

endpackage

[rtl/core/tts_if.sv]
// tts_if.sv: valid/ready channel interfaces for query and result words
// depends on tts_pkg
`timescale 1ns / 1ps

interface tts_in_if;
  import tts_pkg::*;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [TIME_W-1:0] counter_value;

  modport source (output valid, output req_type, output counter_value, input ready);
  modport sink   (input valid, input req_type, input counter_value, output ready);
endinterface

interface tts_out_if;
  import tts_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] elapsed_time;
  logic              product_overflow;

  modport source (output valid, output elapsed_time, output product_overflow, input ready);
  modport sink   (input valid, input elapsed_time, input product_overflow, output ready);
endinterface

[rtl/core/tts_div.sv]
// tts_div.sv: radix-2 restoring divider, 64 or 32 dividend bits by 32 divisor bits
// one quotient bit per cycle; depends on tts_pkg
`timescale 1ns / 1ps

module tts_div (
  input  logic                          clk,
  input  logic                          rst,
  input  tts_pkg::div_ctl_t             ctl,
  input  logic [tts_pkg::TIME_W-1:0]    dividend,
  input  logic [tts_pkg::FREQ_W-1:0]    divisor,
  output logic                          busy,
  output logic                          done,
  output logic [tts_pkg::TIME_W-1:0]    quotient,
  output logic [tts_pkg::FREQ_W-1:0]    remainder
);
  import tts_pkg::*;

  logic              run;
  logic [CNT_W-1:0]  cnt;
  logic [TIME_W-1:0] dvd;
  logic [TIME_W-1:0] quo;
  logic [FREQ_W-1:0] rem;
  logic [FREQ_W-1:0] dsr;
  logic [FREQ_W:0]   trial;
  logic              fits;

  assign trial = {rem, dvd[TIME_W-1]};
  assign fits  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        run <= 1'b1;
        cnt <= ctl.len32 ? DIV_STEPS_SHORT : DIV_STEPS_LONG;
      end else if (run) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd <= ctl.len32 ? {dividend[FREQ_W-1:0], {FREQ_W{1'b0}}} : dividend;
      quo <= '0;
      rem <= '0;
      dsr <= divisor;
    end else if (run) begin
      dvd <= {dvd[TIME_W-2:0], 1'b0};
      quo <= {quo[TIME_W-2:0], fits};
      // a zero divisor always "fits": every quotient bit comes out as one
      rem <= fits ? trial[FREQ_W-1:0] - dsr : trial[FREQ_W-1:0];
    end
  end

  assign busy      = run;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

[rtl/core/tick_to_time_scaler.sv]
// tick_to_time_scaler: a later query runs these steps after acceptance to give its result word
// (subtract, two products of 32-bit counter halves, sum, then 64 steps of the shared divider)
// first query adds the ratio reduction: euclid steps, then the numerator and denominator divides
// on the shared divider, at most about 100 steps for both units together
// one query at a time; a finished word waits in the out register
// rst (sync, high): not started, tick_frequency back to 1000000, no word pending
`timescale 1ns / 1ps

module tick_to_time_scaler (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [tts_pkg::FREQ_W-1:0] cfg_wr_data,
  tts_in_if.sink                     in_ch,
  tts_out_if.source                  out_ch
);
  import tts_pkg::*;

  `include "tick_to_time_scaler_macros.svh"

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GCD   = 4'd1;   // test y, launch x mod y
  localparam logic [3:0] S_GCD_W = 4'd2;
  localparam logic [3:0] S_NUM   = 4'd3;   // launch per_sec / g
  localparam logic [3:0] S_NUM_W = 4'd4;
  localparam logic [3:0] S_DEN   = 4'd5;   // launch freq / g
  localparam logic [3:0] S_DEN_W = 4'd6;
  localparam logic [3:0] S_SUB   = 4'd7;
  localparam logic [3:0] S_MUL_L = 4'd8;
  localparam logic [3:0] S_MUL_H = 4'd9;
  localparam logic [3:0] S_SUM   = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_DIV_W = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  localparam int PP_W  = FREQ_W + NS_NUM_W;      // partial product width
  localparam int SUM_W = PP_W + FREQ_W;          // exact product width

  logic [3:0]          state;
  logic [3:0]          state_next;

  // configuration
  logic [FREQ_W-1:0]   tick_frequency;

  // latched query
  logic                req;
  logic [TIME_W-1:0]   now;

  // start point and reduced ratios
  logic                started;
  logic [TIME_W-1:0]   start_count;
  logic [MS_NUM_W-1:0] ms_numerator;
  logic [FREQ_W-1:0]   ms_denominator;
  logic [NS_NUM_W-1:0] ns_numerator;
  logic [FREQ_W-1:0]   ns_denominator;

  // euclid working pair; x ends as the gcd
  logic [FREQ_W-1:0]   gx;
  logic [FREQ_W-1:0]   gy;
  logic                phase_ns;   // reduction in progress is for nanoseconds

  // product path
  logic [TIME_W-1:0]   ticks;
  logic [PP_W-1:0]     pp_lo;
  logic [PP_W-1:0]     pp_hi;
  logic [PP_W-1:0]     mul_p;
  logic [FREQ_W-1:0]   mul_a;
  logic [NS_NUM_W-1:0] num_sel;
  logic [FREQ_W-1:0]   den_sel;
  logic [SUM_W-1:0]    full_prod;
  logic [TIME_W-1:0]   prod;
  logic                ovf;

  // output register
  logic                out_valid;
  logic [TIME_W-1:0]   out_time;
  logic                out_ovf;
  logic                out_load;

  // shared divider
  div_ctl_t            div_ctl;
  logic [TIME_W-1:0]   div_dividend;
  logic [FREQ_W-1:0]   div_divisor;
  logic                div_busy;
  logic                div_done;
  logic [TIME_W-1:0]   div_quo;
  logic [FREQ_W-1:0]   div_rem;
  logic [FREQ_W-1:0]   per_sec;
  logic                div_wait;   // some step waits on the divider

  logic                in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign per_sec = phase_ns ? NS_PER_SEC : MS_PER_SEC;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_frequency <= FREQ_RESET;
    end else if (cfg_wr_en) begin
      tick_frequency <= cfg_wr_data;
    end
  end

  // ratio for the requested unit
  always_comb begin
    unique case (req)
      REQ_MS: begin
        num_sel = NS_NUM_W'(ms_numerator);
        den_sel = ms_denominator;
      end
      REQ_NS: begin
        num_sel = ns_numerator;
        den_sel = ns_denominator;
      end
      default: begin
        num_sel = '0;
        den_sel = '0;
      end
    endcase
  end

  // one 32 x 30 multiplier, used for the low then the high counter half
  assign mul_a = (state == S_MUL_L) ? ticks[FREQ_W-1:0] : ticks[TIME_W-1:FREQ_W];
  assign mul_p = PP_W'(mul_a) * PP_W'(num_sel);

  // exact product; bits above 64 mean the wrapped product lost something
  assign full_prod = {pp_hi, {FREQ_W{1'b0}}} + SUM_W'(pp_lo);
  assign prod      = full_prod[TIME_W-1:0];

  // divider operand and launch selection
  always_comb begin
    div_ctl      = '0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state)
      S_GCD: begin
        div_ctl.start = (gy != '0);
        div_ctl.len32 = 1'b1;
        div_dividend  = TIME_W'(gx);
        div_divisor   = gy;
      end
      S_NUM: begin
        div_ctl.start = 1'b1;
        div_ctl.len32 = 1'b1;
        div_dividend  = TIME_W'(per_sec);
        div_divisor   = gx;
      end
      S_DEN: begin
        div_ctl.start = 1'b1;
        div_ctl.len32 = 1'b1;
        div_dividend  = TIME_W'(tick_frequency);
        div_divisor   = gx;
      end
      S_DIV: begin
        // zero denominator: restoring steps give all ones
        div_ctl.start = 1'b1;
        div_ctl.len32 = 1'b0;
        div_dividend  = prod;
        div_divisor   = den_sel;
      end
      default: begin
        div_ctl = '0;
      end
    endcase
  end

  tts_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (div_ctl),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign div_wait = (state == S_GCD_W) || (state == S_NUM_W) ||
                    (state == S_DEN_W) || (state == S_DIV_W);

  // the finished word may enter once the previous one has gone or is leaving
  assign out_load = (state == S_OUT) && (!out_valid || out_ch.ready);

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_fire) state_next = started ? S_SUB : S_GCD;
      S_GCD:   state_next = (gy == '0) ? S_NUM : S_GCD_W;
      S_GCD_W: if (div_done) state_next = S_GCD;
      S_NUM:   state_next = S_NUM_W;
      S_NUM_W: if (div_done) state_next = S_DEN;
      S_DEN:   state_next = S_DEN_W;
      S_DEN_W: if (div_done) state_next = phase_ns ? S_SUB : S_GCD;
      S_SUB:   state_next = S_MUL_L;
      S_MUL_L: state_next = S_MUL_H;
      S_MUL_H: state_next = S_SUM;
      S_SUM:   state_next = S_DIV;
      S_DIV:   state_next = S_DIV_W;
      S_DIV_W: if (div_done) state_next = S_OUT;
      S_OUT:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      started        <= 1'b0;
      phase_ns       <= 1'b0;
      out_valid      <= 1'b0;
      start_count    <= '0;
      ms_numerator   <= '0;
      ms_denominator <= '0;
      ns_numerator   <= '0;
      ns_denominator <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_fire && !started) begin
        phase_ns <= 1'b0;
      end
      if (state == S_NUM_W && div_done) begin
        if (phase_ns) begin
          ns_numerator <= div_quo[NS_NUM_W-1:0];
        end else begin
          ms_numerator <= div_quo[MS_NUM_W-1:0];
        end
      end
      if (state == S_DEN_W && div_done) begin
        if (phase_ns) begin
          ns_denominator <= div_quo[FREQ_W-1:0];
          started        <= 1'b1;
          // a zero start point is kept as all ones
          start_count    <= (now == '0) ? '1 : now;
        end else begin
          ms_denominator <= div_quo[FREQ_W-1:0];
          phase_ns       <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req <= in_ch.req_type;
      now <= in_ch.counter_value;
    end
    // euclid pair load at the start of each unit's reduction
    if ((state == S_IDLE && in_fire && !started)) begin
      gx <= MS_PER_SEC;
      gy <= tick_frequency;
    end else if (state == S_DEN_W && div_done && !phase_ns) begin
      gx <= NS_PER_SEC;
      gy <= tick_frequency;
    end else if (state == S_GCD_W && div_done) begin
      gx <= gy;
      gy <= div_rem;
    end
    if (state == S_SUB) begin
      ticks <= now - start_count;
    end
    if (state == S_MUL_L) begin
      pp_lo <= mul_p;
    end
    if (state == S_MUL_H) begin
      pp_hi <= mul_p;
    end
    if (state == S_SUM) begin
      ovf <= |full_prod[SUM_W-1:TIME_W];
    end
    if (out_load) begin
      out_time <= div_quo;
      out_ovf  <= ovf;
    end
  end

  assign in_ch.ready             = (state == S_IDLE);
  assign out_ch.valid            = out_valid;
  assign out_ch.elapsed_time     = out_time;
  assign out_ch.product_overflow = out_ovf;

  // checks
  `TTS_ASSERT_NOW(a_done_expected, div_done, div_wait, "divider finished while no step waits")
  `TTS_ASSERT_NOW(a_accept_div_idle, in_fire, !div_busy, "query taken while divider busy")
  `TTS_ASSERT_NOW(a_product_after_start, state == S_SUB, started, "product step before start")
  `TTS_ASSERT_NEXT(a_started_holds, started, started, "start point lost outside reset")

endmodule
